// ===== hdl/cpsc_pkg.sv =====
`default_nettype none

package cpsc_pkg;

	localparam int MvW = 15;

	typedef logic signed [MvW-1:0] mv_t;

	typedef enum logic [2:0] {
		ST_A    = 3'd0,
		ST_B    = 3'd1,
		ST_C    = 3'd2,
		ST_D    = 3'd3,
		ST_E    = 3'd4,
		ST_F    = 3'd5,
		ST_DISC = 3'd6
	} pilot_state_t;

	typedef enum logic [1:0] {
		FLT_NONE  = 2'd0,
		FLT_PILOT = 2'd1,
		FLT_DIODE = 2'd2,
		FLT_SHORT = 2'd3
	} fault_code_t;

	// window bounds in millivolts
	localparam mv_t A_HI  = 15'sd13000;
	localparam mv_t A_LO  = 15'sd11000;
	localparam mv_t B_HI  = 15'sd10000;
	localparam mv_t B_LO  = 15'sd8000;
	localparam mv_t C_HI  = 15'sd7000;
	localparam mv_t C_LO  = 15'sd5000;
	localparam mv_t D_HI  = 15'sd4000;
	localparam mv_t D_LO  = 15'sd2000;
	localparam mv_t E_HI  = 15'sd1500;
	localparam mv_t E_LO  = -15'sd1500;
	localparam mv_t F_HI  = -15'sd11000;
	localparam mv_t F_LO  = -15'sd13000;

	// register indexes
	localparam logic REG_ENABLED = 1'b0;

	function automatic pilot_state_t classify(input mv_t mv);
		pilot_state_t cls;
		if (mv > A_HI)        cls = ST_DISC;
		else if (mv >= A_LO)  cls = ST_A;
		else if (mv >= B_HI)  cls = ST_DISC;
		else if (mv >= B_LO)  cls = ST_B;
		else if (mv >= C_HI)  cls = ST_DISC;
		else if (mv >= C_LO)  cls = ST_C;
		else if (mv >= D_HI)  cls = ST_DISC;
		else if (mv >= D_LO)  cls = ST_D;
		else if (mv >= E_HI)  cls = ST_DISC;
		else if (mv >= E_LO)  cls = ST_E;
		else if (mv >= F_HI)  cls = ST_DISC;
		else if (mv >= F_LO)  cls = ST_F;
		else                  cls = ST_DISC;
		return cls;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/control_pilot_state_classifier_unit.sv =====
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+-----------------------------------------------
// in       | in_valid  | in_stall  | positive_mv, negative_mv, pwm_active
// out      | out_valid | out_stall | state_changed, pilot_state, fault_event,
//          |           |           | fault_code
// cfg      | apb write | pready=1  | paddr, pwdata (enabled at byte address 0)
//
// one word per cycle sustained while the output is not stalled; a taken word passes
// through the input register, then the window compares and the state update land in
// the result register
// the last state and fault flag are updated as a word moves into the result register
// reset clears the enable, sets the last state to disconnected and drops the fault flag
// a stalled result holds the result register; the input register takes a word while
// it is empty, or while the result register is free or being taken in the same cycle
`default_nettype none

module control_pilot_state_classifier_unit import cpsc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [14:0] positive_mv,
	input  wire logic [14:0] negative_mv,
	input  wire logic        pwm_active,
	// output channel
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic        state_changed,
	output      logic [2:0]  pilot_state,
	output      logic        fault_event,
	output      logic [1:0]  fault_code,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);

	// input register
	logic  valid_s1;
	mv_t   pos_s1;
	mv_t   neg_s1;
	logic  pwm_s1;

	// result register
	logic         valid_s2;
	logic         changed_s2;
	pilot_state_t state_s2;
	logic         event_s2;
	fault_code_t  code_s2;

	// block state
	logic         enabled_q;
	pilot_state_t last_state_q;
	logic         fault_raised_q;

	logic advance;
	logic in_take;
	logic cfg_wr;
	logic reg_hit;

	// combinational result for the word in the input register
	pilot_state_t pos_cls;
	pilot_state_t neg_cls;
	pilot_state_t st_c;
	fault_code_t  code_c;
	logic         changed_c;
	logic         event_c;
	pilot_state_t last_state_d;
	logic         fault_raised_d;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_ENABLED);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = reg_hit ? {31'd0, enabled_q} : 32'd0;

	// the input register moves on when the result register is empty or drained now
	assign advance  = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign in_take  = in_valid && !in_stall;

	always_comb begin
		pos_cls = classify(pos_s1);
		neg_cls = classify(neg_s1);

		// combine the two plateaus, pwm off forces E
		st_c = pos_cls;
		if (pos_cls == ST_E && neg_cls == ST_F) begin
			st_c = ST_F;
		end
		if (!pwm_s1) begin
			st_c = ST_E;
		end

		// fault priority: short over diode over pilot
		code_c = FLT_NONE;
		if (pos_cls == ST_DISC && neg_cls == ST_DISC) begin
			st_c   = ST_DISC;
			code_c = FLT_PILOT;
		end
		if ((st_c == ST_B || st_c == ST_C || st_c == ST_D) && neg_cls == ST_DISC) begin
			code_c = FLT_DIODE;
		end
		if (pwm_s1 && pos_cls == ST_E && neg_cls == ST_E) begin
			code_c = FLT_SHORT;
		end

		changed_c      = 1'b0;
		event_c        = 1'b0;
		last_state_d   = last_state_q;
		fault_raised_d = fault_raised_q;

		if (!enabled_q) begin
			// disabled: report the held state, no events
			st_c   = last_state_q;
			code_c = FLT_NONE;
		end else if (code_c != FLT_NONE) begin
			// a fault is announced once, state follows silently
			last_state_d   = st_c;
			event_c        = !fault_raised_q;
			fault_raised_d = 1'b1;
		end else begin
			// announce the clearing, then look for a state change
			event_c        = fault_raised_q;
			fault_raised_d = 1'b0;
			if (last_state_q != st_c) begin
				changed_c    = 1'b1;
				last_state_d = st_c;
			end
		end
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			enabled_q      <= 1'b0;
			last_state_q   <= ST_DISC;
			fault_raised_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end

			// the user must write configuration only while idle, the block does not enforce it; a disable drops the last state
			if (cfg_wr && reg_hit && !pwdata[0]) begin
				last_state_q <= ST_DISC;
			end else if (advance) begin
				last_state_q <= last_state_d;
			end

			if (advance) begin
				fault_raised_q <= fault_raised_d;
			end

			if (cfg_wr && reg_hit) begin
				enabled_q <= pwdata[0];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			pos_s1 <= positive_mv;
			neg_s1 <= negative_mv;
			pwm_s1 <= pwm_active;
		end
		if (advance) begin
			changed_s2 <= changed_c;
			state_s2   <= st_c;
			event_s2   <= event_c;
			code_s2    <= code_c;
		end
	end

	assign out_valid     = valid_s2;
	assign state_changed = changed_s2;
	assign pilot_state   = state_s2;
	assign fault_event   = event_s2;
	assign fault_code    = code_s2;

`ifndef SYNTHESIS
	// a state change is only announced with no fault present
	a_change_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && state_changed) |-> (fault_code == FLT_NONE))
		else $error("state change reported together with a fault");

	// a pilot fault always reports the disconnected state
	a_pilot_fault_disc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fault_code == FLT_PILOT) |-> (pilot_state == ST_DISC))
		else $error("pilot fault without disconnected state");

	// raising the fault flag goes out as a fault event
	a_fault_rise_event: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fault_raised_q) |-> (out_valid && fault_event && fault_code != FLT_NONE))
		else $error("fault flag raised without a fault event");

	// disabling resets the last state
	a_disable_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && reg_hit && !pwdata[0]) |=> (last_state_q == ST_DISC && !enabled_q))
		else $error("disable did not reset the last state");
`endif

endmodule

`default_nettype wire
